/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks clocked on clk and held off while arst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check
`define RSE_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// same-cycle implication
`define RSE_ASSERT_IMP(label, cond, prop, msg) \
	`RSE_ASSERT(label, (cond) |-> (prop), msg)

`endif

/* design/rse_pkg.sv */
// ----------------------------------------------------------------------------
// rse_pkg
// shared types and constants of the postfix stack evaluator
// ----------------------------------------------------------------------------
package rse_pkg;

	localparam int RSE_STACK_DEPTH = 128;
	localparam int RSE_FRAC_BITS   = 16;
	localparam int WORD_W          = 32;
	localparam int LEVEL_W         = 8;

	localparam int IN_TDATA_W  = 32;
	localparam int IN_TUSER_W  = 3;
	localparam int OUT_TDATA_W = 40;
	localparam int OUT_TUSER_W = 4;

	localparam logic [WORD_W-1:0] SAT_POS = 32'h7FFF_FFFF;
	localparam logic [WORD_W-1:0] SAT_NEG = 32'h8000_0000;

	typedef enum logic [2:0] {
		FN_PUSH  = 3'd0,
		FN_ADD   = 3'd1,
		FN_SUB   = 3'd2,
		FN_MUL   = 3'd3,
		FN_DIV   = 3'd4,
		FN_PRINT = 3'd5
	} func_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_FULL    = 3'd1,
		ST_EMPTY   = 3'd2,
		ST_DIVZERO = 3'd3,
		ST_UNKNOWN = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_MUL,
		ALU_DIV
	} alu_op_t;

	typedef enum logic [1:0] {
		ALU_IDLE,
		ALU_RUN,
		ALU_FIN,
		ALU_DONE
	} alu_state_t;

	typedef enum logic [2:0] {
		EV_IDLE,
		EV_TOP,
		EV_SEC,
		EV_ALU,
		EV_RESP
	} eval_state_t;

	typedef struct packed {
		logic              start;
		alu_op_t           op;
		logic [WORD_W-1:0] left;
		logic [WORD_W-1:0] right;
	} alu_req_t;

	typedef struct packed {
		logic              done;
		logic [WORD_W-1:0] result;
	} alu_rsp_t;

endpackage

/* design/rse_stack_mem.sv */
// ----------------------------------------------------------------------------
// rse_stack_mem
// operand stack storage, one write port and one registered read port
// ----------------------------------------------------------------------------
module rse_stack_mem #(
	parameter int DEPTH = rse_pkg::RSE_STACK_DEPTH
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [$clog2(DEPTH)-1:0]    waddr,
	input  logic [rse_pkg::WORD_W-1:0]  wdata,
	input  logic [$clog2(DEPTH)-1:0]    raddr,
	output logic [rse_pkg::WORD_W-1:0]  rdata
);
	import rse_pkg::*;

	logic [WORD_W-1:0] mem_q [DEPTH];
	logic [WORD_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* design/rse_alu.sv */
// ----------------------------------------------------------------------------
// rse_alu
// bit-serial Q format arithmetic: add, subtract, multiply, divide, saturating
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rse_alu #(
	parameter int FRAC_BITS = rse_pkg::RSE_FRAC_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rse_pkg::alu_req_t req,
	output rse_pkg::alu_rsp_t rsp
);
	import rse_pkg::*;

	localparam int CNT_W    = $clog2(WORD_W + 1);
	localparam int HI_SHIFT = WORD_W - FRAC_BITS;
	localparam logic [CNT_W-1:0] ADD_LAST = CNT_W'(WORD_W);
	localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(WORD_W - 1);

	alu_state_t state_q, state_d;
	alu_op_t    op_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [WORD_W:0]   x_q;
	logic [WORD_W-1:0] y_q;
	logic [WORD_W:0]   acc_q;
	logic [WORD_W-1:0] lo_q;
	logic              c_q;
	logic              neg_q;
	logic              ovf_q;
	logic [WORD_W-1:0] res_q;

	logic              load, step, fin, last;
	logic [CNT_W-1:0]  last_idx;

	logic [WORD_W-1:0] div_ma, div_mb, div_hi, div_lo;
	logic              add_bl, add_br, add_s, add_c;
	logic [WORD_W:0]   mul_add, mul_sum;
	logic [WORD_W:0]   div_t, div_diff;
	logic              div_ge;
	logic [2*WORD_W-1:0] mul_prod, mul_shr;
	logic [WORD_W:0]   mul_upper;
	logic [WORD_W-1:0] res_d;

	// operand preparation for divide
	always_comb begin
		div_ma = req.left[WORD_W-1] ? WORD_W'(-req.left) : req.left;
		div_mb = req.right[WORD_W-1] ? WORD_W'(-req.right) : req.right;
		div_hi = div_ma >> HI_SHIFT;
		div_lo = div_ma << FRAC_BITS;
	end

	// one bit per cycle
	always_comb begin
		add_bl   = x_q[0];
		add_br   = y_q[0] ^ (op_q == ALU_SUB);
		add_s    = add_bl ^ add_br ^ c_q;
		add_c    = (add_bl & add_br) | (add_bl & c_q) | (add_br & c_q);
		mul_add  = y_q[0] ? x_q : '0;
		mul_sum  = (cnt_q == MUL_LAST) ? (acc_q - mul_add) : (acc_q + mul_add);
		div_t    = {acc_q[WORD_W-1:0], y_q[WORD_W-1]};
		div_ge   = (div_t >= x_q);
		div_diff = div_t - x_q;
		last_idx = ((op_q == ALU_ADD) || (op_q == ALU_SUB)) ? ADD_LAST : MUL_LAST;
		last     = (cnt_q == last_idx);
	end

	// saturation and sign fix-up
	always_comb begin
		mul_prod  = {acc_q[WORD_W-1:0], lo_q};
		mul_shr   = (2*WORD_W)'($signed(mul_prod) >>> FRAC_BITS);
		mul_upper = mul_shr[2*WORD_W-1:WORD_W-1];
		res_d     = acc_q[WORD_W-1:0];
		unique case (op_q)
			ALU_ADD, ALU_SUB: begin
				if (acc_q[WORD_W] != acc_q[WORD_W-1]) begin
					res_d = acc_q[WORD_W] ? SAT_NEG : SAT_POS;
				end else begin
					res_d = acc_q[WORD_W-1:0];
				end
			end
			ALU_MUL: begin
				if ((mul_upper != '0) && (mul_upper != '1)) begin
					res_d = mul_prod[2*WORD_W-1] ? SAT_NEG : SAT_POS;
				end else begin
					res_d = mul_shr[WORD_W-1:0];
				end
			end
			ALU_DIV: begin
				if (!neg_q) begin
					res_d = (ovf_q || lo_q[WORD_W-1]) ? SAT_POS : lo_q;
				end else begin
					res_d = (ovf_q || lo_q[WORD_W-1]) ? SAT_NEG : WORD_W'(-lo_q);
				end
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ALU_IDLE: begin
				if (req.start) begin
					state_d = ALU_RUN;
				end
			end
			ALU_RUN: begin
				if (last) begin
					state_d = ALU_FIN;
				end
			end
			ALU_FIN:  state_d = ALU_DONE;
			ALU_DONE: state_d = ALU_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		load       = (state_q == ALU_IDLE) && req.start;
		step       = (state_q == ALU_RUN);
		fin        = (state_q == ALU_FIN);
		rsp.done   = (state_q == ALU_DONE);
		rsp.result = res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ALU_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			op_q  <= req.op;
			cnt_q <= '0;
			lo_q  <= '0;
			c_q   <= (req.op == ALU_SUB);
			neg_q <= req.left[WORD_W-1] ^ req.right[WORD_W-1];
			ovf_q <= (div_hi >= div_mb);
			if (req.op == ALU_DIV) begin
				x_q   <= {1'b0, div_mb};
				y_q   <= div_lo;
				acc_q <= {1'b0, div_hi};
			end else begin
				x_q   <= {req.left[WORD_W-1], req.left};
				y_q   <= req.right;
				acc_q <= '0;
			end
		end else if (step) begin
			cnt_q <= cnt_q + CNT_W'(1);
			unique case (op_q)
				ALU_ADD, ALU_SUB: begin
					x_q   <= {x_q[WORD_W], x_q[WORD_W:1]};
					y_q   <= {y_q[WORD_W-1], y_q[WORD_W-1:1]};
					acc_q <= {add_s, acc_q[WORD_W:1]};
					c_q   <= add_c;
				end
				ALU_MUL: begin
					y_q   <= {1'b0, y_q[WORD_W-1:1]};
					acc_q <= {mul_sum[WORD_W], mul_sum[WORD_W:1]};
					lo_q  <= {mul_sum[0], lo_q[WORD_W-1:1]};
				end
				ALU_DIV: begin
					y_q   <= {y_q[WORD_W-2:0], 1'b0};
					acc_q <= {1'b0, div_ge ? div_diff[WORD_W-1:0] : div_t[WORD_W-1:0]};
					lo_q  <= {lo_q[WORD_W-2:0], div_ge};
				end
			endcase
		end
		if (fin) begin
			res_q <= res_d;
		end
	end

	`RSE_ASSERT(a_done_pulse, rsp.done |=> !rsp.done, "alu done held longer than one cycle")
	`RSE_ASSERT_IMP(a_start_idle, req.start, state_q == ALU_IDLE, "alu started while busy")

endmodule

/* design/rpn_stack_evaluator_core.sv */
// ----------------------------------------------------------------------------
// rpn_stack_evaluator_core
// postfix calculator over an operand stack of signed fixed point numbers
// ----------------------------------------------------------------------------
// Each input transaction is one token (tuser selects push, add, subtract,
// multiply, divide or print; tdata is the value to push) and gives exactly one
// output transaction with status, printed value, print flag and stack level.
// Push, print and every error go from the top fetch to the response state and
// into the output register; add, subtract, multiply and divide also fetch the
// second operand and wait for the bit-serial ALU, one bit per cycle. The
// stack lives in a single-port-read memory, so the two operands are fetched
// one after the other. A new input is taken as soon as the previous result has
// moved into the output register, even while that result still waits there.
`include "assert_macros.svh"

module rpn_stack_evaluator_core #(
	parameter int STACK_DEPTH = rse_pkg::RSE_STACK_DEPTH,
	parameter int FRAC_BITS   = rse_pkg::RSE_FRAC_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [rse_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // operand_value
	input  logic [rse_pkg::IN_TUSER_W-1:0]  s_axis_tuser,  // func
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [rse_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // result_value, stack_level
	output logic [rse_pkg::OUT_TUSER_W-1:0] m_axis_tuser   // status, result_valid
);
	import rse_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	eval_state_t state_q, state_d;
	func_t             func_q;
	logic [WORD_W-1:0] opnd_q;
	logic [WORD_W-1:0] top_q;
	logic [CW-1:0]     count_q;
	status_t           status_q;
	logic [WORD_W-1:0] rval_q;
	logic              rvalid_q;

	logic              m_valid_q;
	status_t           out_status_q;
	logic [WORD_W-1:0] out_value_q;
	logic              out_rvalid_q;
	logic [LEVEL_W-1:0] out_level_q;

	logic [CW-1:0]     cnt_m1, cnt_m2;
	logic              has1, has2, full, top_zero, out_free, accept;
	status_t           dec_status;
	logic              dec_alu, dec_push, dec_pop;
	alu_op_t           dec_op;

	logic              mem_we;
	logic [AW-1:0]     mem_waddr, mem_raddr;
	logic [WORD_W-1:0] mem_wdata, mem_rdata;
	alu_req_t          alu_req;
	alu_rsp_t          alu_rsp;

	rse_stack_mem #(
		.DEPTH(STACK_DEPTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	rse_alu #(
		.FRAC_BITS(FRAC_BITS)
	) u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.rsp    (alu_rsp)
	);

	// token decode against the fetched top entry
	always_comb begin
		cnt_m1     = count_q - CW'(1);
		cnt_m2     = count_q - CW'(2);
		has1       = (count_q != '0);
		has2       = (count_q >= CW'(2));
		full       = (count_q == CW'(STACK_DEPTH));
		top_zero   = (mem_rdata == '0);
		out_free   = !m_valid_q || m_axis_tready;
		accept     = s_axis_tvalid && s_axis_tready;
		dec_status = ST_OK;
		dec_alu    = 1'b0;
		dec_push   = 1'b0;
		dec_pop    = 1'b0;
		dec_op     = ALU_ADD;
		unique case (func_q)
			FN_PUSH: begin
				if (full) begin
					dec_status = ST_FULL;
				end else begin
					dec_push = 1'b1;
				end
			end
			FN_ADD, FN_SUB, FN_MUL: begin
				dec_op = (func_q == FN_ADD) ? ALU_ADD :
				         (func_q == FN_SUB) ? ALU_SUB : ALU_MUL;
				if (has2) begin
					dec_alu = 1'b1;
				end else begin
					dec_status = ST_EMPTY;
				end
			end
			FN_DIV: begin
				dec_op = ALU_DIV;
				priority if (!has1) begin
					dec_status = ST_EMPTY;
				end else if (top_zero) begin
					dec_status = ST_DIVZERO;
				end else if (!has2) begin
					dec_status = ST_EMPTY;
				end else begin
					dec_alu = 1'b1;
				end
			end
			FN_PRINT: begin
				if (has1) begin
					dec_pop = 1'b1;
				end else begin
					dec_status = ST_EMPTY;
				end
			end
			default: dec_status = ST_UNKNOWN;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			EV_IDLE: begin
				if (s_axis_tvalid) begin
					state_d = EV_TOP;
				end
			end
			EV_TOP: state_d = dec_alu ? EV_SEC : EV_RESP;
			EV_SEC: state_d = EV_ALU;
			EV_ALU: begin
				if (alu_rsp.done) begin
					state_d = EV_RESP;
				end
			end
			EV_RESP: begin
				if (out_free) begin
					state_d = EV_IDLE;
				end
			end
		endcase
	end

	// outputs
	always_comb begin
		s_axis_tready = (state_q == EV_IDLE);
		mem_raddr     = (state_q == EV_TOP) ? cnt_m2[AW-1:0] : cnt_m1[AW-1:0];
		mem_we        = 1'b0;
		mem_waddr     = count_q[AW-1:0];
		mem_wdata     = opnd_q;
		if ((state_q == EV_TOP) && dec_push) begin
			mem_we = 1'b1;
		end else if ((state_q == EV_ALU) && alu_rsp.done) begin
			mem_we    = 1'b1;
			mem_waddr = cnt_m2[AW-1:0];
			mem_wdata = alu_rsp.result;
		end
		alu_req.start = (state_q == EV_SEC);
		alu_req.op    = dec_op;
		alu_req.left  = mem_rdata;
		alu_req.right = top_q;
		m_axis_tvalid = m_valid_q;
		m_axis_tdata  = {out_level_q, out_value_q};
		m_axis_tuser  = {out_rvalid_q, out_status_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= EV_IDLE;
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == EV_TOP) begin
				if (dec_push) begin
					count_q <= count_q + CW'(1);
				end else if (dec_pop) begin
					count_q <= cnt_m1;
				end
			end else if ((state_q == EV_ALU) && alu_rsp.done) begin
				count_q <= cnt_m1;
			end
			if ((state_q == EV_RESP) && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q <= func_t'(s_axis_tuser);
			opnd_q <= s_axis_tdata[WORD_W-1:0];
		end
		if (state_q == EV_TOP) begin
			top_q    <= mem_rdata;
			status_q <= dec_status;
			rval_q   <= dec_pop ? mem_rdata : '0;
			rvalid_q <= dec_pop;
		end
		if ((state_q == EV_RESP) && out_free) begin
			out_status_q <= status_q;
			out_value_q  <= rval_q;
			out_rvalid_q <= rvalid_q;
			out_level_q  <= LEVEL_W'(count_q);
		end
	end

	`RSE_ASSERT(a_count_range, count_q <= CW'(STACK_DEPTH), "stack count beyond depth")
	`RSE_ASSERT_IMP(a_done_in_alu, alu_rsp.done, state_q == EV_ALU, "alu result outside wait")
	`RSE_ASSERT(a_resp_load, ((state_q == EV_RESP) && out_free) |=> (m_axis_tvalid && (state_q == EV_IDLE)), "result not loaded")

endmodule
